### src/ordered_list_engine_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list engine
// Shared implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OLU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olu port check failed");

// next-cycle implication, disabled during reset
`define OLU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olu port check failed");

`endif

### src/olu_pkg.sv
// ----------------------------------------------------------------------------
// olu_pkg
// Operation codes, status codes and controller command type.
// ----------------------------------------------------------------------------
package olu_pkg;

    localparam logic [2:0] MODE_INSERT    = 3'd0;
    localparam logic [2:0] MODE_DEL_VALUE = 3'd1;
    localparam logic [2:0] MODE_DEL_POS   = 3'd2;
    localparam logic [2:0] MODE_SEARCH    = 3'd3;
    localparam logic [2:0] MODE_READ      = 3'd4;
    localparam logic [2:0] MODE_MODIFY    = 3'd5;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [7:0] POS_TAIL = 8'hFF;

    typedef struct packed {
        logic load;   // capture the input transfer
        logic cmp;    // match every cell, register hit vector
        logic exec;   // apply operation, load result register
    } t_olu_cmd;

endpackage

### src/olu_ctrl.sv
// ----------------------------------------------------------------------------
// olu_ctrl
// Sequencer: capture, compare, execute; owns the result valid flag.
// ----------------------------------------------------------------------------
module olu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output olu_pkg::t_olu_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || !i_out_stall;

    assign o_cmd.load = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.cmp  = (r_state == S_CMP);
    assign o_cmd.exec = (r_state == S_EXEC) && slot_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    // hold until the result register can take a new transfer
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### src/olu_dpath.sv
// ----------------------------------------------------------------------------
// olu_dpath
// Cell row with parallel compare, shift on insert/delete, result register.
// ----------------------------------------------------------------------------
module olu_dpath #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  olu_pkg::t_olu_cmd  i_cmd,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_value,
    input  logic signed [7:0]  i_position,
    input  logic signed [31:0] i_new_value,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_result_value,
    output logic [6:0]         o_result_position,
    output logic [6:0]         o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int XW = ((CW > 7) ? CW : 7) + 1;

    // captured transfer
    logic [2:0]  r_mode;
    logic [31:0] r_value;
    logic [7:0]  r_pos;
    logic [31:0] r_new_value;

    // list state
    logic [31:0]   r_cells [DEPTH];
    logic [31:0]   n_cells [DEPTH];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // compare stage
    logic [DEPTH-1:0] r_hit;
    logic [DEPTH-1:0] n_hit;
    logic             r_ok;
    logic             n_ok;

    // result register
    logic [1:0]  r_status;
    logic [31:0] r_rval;
    logic [6:0]  r_rpos;
    logic [6:0]  r_cnt_out;
    logic [1:0]  n_status;
    logic [31:0] n_rval;
    logic [CW-1:0] n_rpos;

    // position decode
    logic [XW-1:0] posx;
    logic [XW-1:0] cntx;
    logic [XW-1:0] at_ins;
    logic [XW-1:0] at_acc;
    logic          pos_pos;
    logic          tail;
    logic          ins_ok;
    logic          acc_ok;

    // execute stage
    logic [DEPTH-1:0] first;
    logic [DEPTH-1:0] ge;
    logic             found;
    logic             full;
    logic [IW-1:0]    idx;
    logic             do_ins;
    logic             do_del;
    logic             do_mod;
    logic [CW+6:0]    ext_cnt;
    logic [CW+6:0]    ext_pos;

    assign posx    = XW'(r_pos[6:0]);
    assign cntx    = XW'(r_count);
    assign pos_pos = !r_pos[7] && (r_pos[6:0] != 7'd0);
    assign tail    = (r_pos == olu_pkg::POS_TAIL);
    assign ins_ok  = tail || (pos_pos && (posx <= cntx + XW'(1)));
    assign acc_ok  = pos_pos && (posx <= cntx);
    assign at_ins  = tail ? cntx : posx - XW'(1);
    assign at_acc  = posx - XW'(1);

    always_comb begin
        n_hit = '0;
        n_ok  = 1'b0;
        case (r_mode)
            olu_pkg::MODE_INSERT: begin
                n_ok = ins_ok;
                for (int k = 0; k < DEPTH; k++) begin
                    n_hit[k] = (XW'(k) == at_ins);
                end
            end
            olu_pkg::MODE_DEL_POS, olu_pkg::MODE_READ: begin
                n_ok = acc_ok;
                for (int k = 0; k < DEPTH; k++) begin
                    n_hit[k] = (XW'(k) == at_acc);
                end
            end
            olu_pkg::MODE_DEL_VALUE, olu_pkg::MODE_SEARCH, olu_pkg::MODE_MODIFY: begin
                n_ok = 1'b1;
                for (int k = 0; k < DEPTH; k++) begin
                    n_hit[k] = (r_cells[k] == r_value) && (XW'(k) < cntx);
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // isolate lowest hit and the mask of cells at or above it
    assign first = r_hit & (~r_hit + DEPTH'(1));
    assign ge    = ~(first - DEPTH'(1));
    assign found = |r_hit;
    assign full  = (r_count == CW'(DEPTH));

    always_comb begin
        idx    = '0;
        n_rval = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (first[k]) begin
                idx    = idx | IW'(k);
                n_rval = n_rval | r_cells[k];
            end
        end
    end

    always_comb begin
        do_ins   = 1'b0;
        do_del   = 1'b0;
        do_mod   = 1'b0;
        n_status = olu_pkg::ST_MISS;
        n_count  = r_count;
        n_rpos   = '0;
        case (r_mode)
            olu_pkg::MODE_INSERT: begin
                if (r_ok && full) begin
                    n_status = olu_pkg::ST_FULL;
                end else if (r_ok) begin
                    do_ins   = 1'b1;
                    n_status = olu_pkg::ST_DONE;
                    n_count  = r_count + CW'(1);
                end
            end
            olu_pkg::MODE_DEL_VALUE, olu_pkg::MODE_DEL_POS: begin
                if (r_ok && found) begin
                    do_del   = 1'b1;
                    n_status = olu_pkg::ST_DONE;
                    n_count  = r_count - CW'(1);
                end
            end
            olu_pkg::MODE_SEARCH: begin
                if (found) begin
                    n_status = olu_pkg::ST_DONE;
                    n_rpos   = CW'(idx) + CW'(1);
                end
            end
            olu_pkg::MODE_READ: begin
                if (r_ok && found) begin
                    n_status = olu_pkg::ST_DONE;
                end
            end
            olu_pkg::MODE_MODIFY: begin
                if (found) begin
                    do_mod   = 1'b1;
                    n_status = olu_pkg::ST_DONE;
                end
            end
            default: begin
                n_status = olu_pkg::ST_MISS;
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            n_cells[k] = r_cells[k];
            if (do_ins && ge[k]) begin
                n_cells[k] = first[k] ? r_value : r_cells[(k > 0) ? k - 1 : 0];
            end else if (do_del && ge[k]) begin
                n_cells[k] = r_cells[(k < DEPTH - 1) ? k + 1 : k];
            end else if (do_mod && first[k]) begin
                n_cells[k] = r_new_value;
            end
        end
    end

    assign ext_cnt = {7'd0, n_count};
    assign ext_pos = {7'd0, n_rpos};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode      <= i_mode;
            r_value     <= i_value;
            r_pos       <= i_position;
            r_new_value <= i_new_value;
        end
        if (i_cmd.cmp) begin
            r_hit <= n_hit;
            r_ok  <= n_ok;
        end
        if (i_cmd.exec) begin
            r_cells   <= n_cells;
            r_status  <= n_status;
            r_rval    <= (r_mode == olu_pkg::MODE_READ && r_ok && found) ? n_rval : 32'd0;
            r_rpos    <= ext_pos[6:0];
            r_cnt_out <= ext_cnt[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_status          = r_status;
    assign o_result_value    = r_rval;
    assign o_result_position = r_rpos;
    assign o_entry_count     = r_cnt_out;

endmodule

### src/ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Bounded ordered list of signed 32-bit values with insert, delete, search,
// read and modify, built as a row of cells with parallel compare and shift.
// ----------------------------------------------------------------------------
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+---------------------------------------
//   input   | i_in_valid  | o_in_stall   | i_mode i_value i_position i_new_value
//   output  | o_out_valid | i_out_stall  | o_status o_result_value
//           |             |              | o_result_position o_entry_count
//
// One operation at a time: capture, compare across all cells, execute.
// The execute step does the shift/update over the cell row and loads the
// output register; the input stays stalled until that step is taken.
// A stalled result holds the execute stage; a new input is still taken
// while the result waits. Synchronous active-low reset empties the list.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_value,
    input  logic signed [7:0]  i_position,
    input  logic signed [31:0] i_new_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_result_value,
    output logic [6:0]         o_result_position,
    output logic [6:0]         o_entry_count
);

    olu_pkg::t_olu_cmd cmd;

    olu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    olu_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_mode            (i_mode),
        .i_value           (i_value),
        .i_position        (i_position),
        .i_new_value       (i_new_value),
        .o_status          (o_status),
        .o_result_value    (o_result_value),
        .o_result_position (o_result_position),
        .o_entry_count     (o_entry_count)
    );

endmodule

### src/olu_checker.sv
// ----------------------------------------------------------------------------
// olu_checker
// Port-level checks on the ordered list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "ordered_list_engine_unit_assert.svh"

module olu_checker #(
    parameter int DEPTH = 64
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [2:0]         i_mode,
    input logic signed [31:0] i_value,
    input logic signed [7:0]  i_position,
    input logic signed [31:0] i_new_value,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_status,
    input logic signed [31:0] o_result_value,
    input logic [6:0]         o_result_position,
    input logic [6:0]         o_entry_count
);

    localparam logic [6:0] DEPTH_LOW = 7'(DEPTH);

    // one operation at a time: a transfer closes the input until done
    `OLU_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a reported position only comes with a successful search
    `OLU_ASSERT_IMP(a_pos_means_done, i_clk, i_rst_n, o_out_valid && (o_result_position != 7'd0), o_status == olu_pkg::ST_DONE)

    // list full is reported only when the count sits at capacity
    `OLU_ASSERT_IMP(a_full_at_depth, i_clk, i_rst_n, o_out_valid && (o_status == olu_pkg::ST_FULL), o_entry_count == DEPTH_LOW)

    // a stalled result stays offered
    `OLU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

endmodule

bind ordered_list_engine_unit olu_checker #(.DEPTH(DEPTH)) u_olu_checker (.*);

### dv/ordered_list_engine_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_engine_unit_tb
// Drives list operations through the valid/stall input channel and checks
// every result against a cycle-free model of the ordered list. A directed
// table covers empty-list, bad-position and extreme-value cases first. Random
// traffic then grows, churns and drains the list with random idling and stalls.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit_tb;

    localparam int LIST_DEPTH      = 64;
    localparam int ITEMS_PER_BLOCK = 100;
    localparam int RAND_BLOCKS     = 11;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 2000;

    // modes the block does not decode
    localparam logic [2:0] MODE_RSVD_6 = 3'd6;
    localparam logic [2:0] MODE_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] value;
        logic [7:0]  position;
        logic [31:0] new_value;
    } t_op_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [6:0]  match_pos;
        logic [6:0]  entry_count;
    } t_list_result;

    typedef struct packed {
        t_op_item     op;
        bit           typed;
        t_list_result res;
    } t_dir_row;

    typedef enum logic [1:0] {TREND_GROW, TREND_MIXED, TREND_SHRINK} t_fill_trend;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [2:0]         i_mode;
    logic signed [31:0] i_value;
    logic signed [7:0]  i_position;
    logic signed [31:0] i_new_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_status;
    logic signed [31:0] o_result_value;
    logic [6:0]         o_result_position;
    logic [6:0]         o_entry_count;

    // list model state
    logic [31:0] model_cells [LIST_DEPTH];
    int          model_len = 0;

    t_list_result pending_results[$];
    t_dir_row     dir_table[$];

    t_op_item     offer_op;
    bit           offer_typed;
    t_list_result offer_res;

    bit src_quiet  = 1'b0;
    bit sink_quiet = 1'b0;
    bit hold_req   = 1'b0;

    int err_count      = 0;
    int ops_sent       = 0;
    int results_seen   = 0;
    int full_rejects   = 0;
    int miss_count     = 0;
    int max_len_seen   = 0;
    int mode_tally [8] = '{default: 0};
    int idle_cycles    = 0;

    ordered_list_engine_unit #(
        .DEPTH(LIST_DEPTH)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_value          (i_value),
        .i_position       (i_position),
        .i_new_value      (i_new_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_result_value   (o_result_value),
        .o_result_position(o_result_position),
        .o_entry_count    (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // apply one operation to the model list and return its result
    function automatic t_list_result apply_list_op(t_op_item op);
        t_list_result r;
        int p;
        int at;
        int hit;
        int k;
        r = '0;
        r.status = olu_pkg::ST_MISS;
        p = int'($signed(op.position));
        hit = -1;
        for (k = 0; k < model_len; k++) begin
            if (hit < 0 && model_cells[k] == op.value) hit = k;
        end
        case (op.mode)
            olu_pkg::MODE_INSERT: begin
                if (p == -1) at = model_len;
                else if (p >= 1 && p <= model_len + 1) at = p - 1;
                else at = -1;
                if (at >= 0) begin
                    if (model_len >= LIST_DEPTH) begin
                        r.status = olu_pkg::ST_FULL;
                    end else begin
                        for (k = model_len; k > at; k--) model_cells[k] = model_cells[k - 1];
                        model_cells[at] = op.value;
                        model_len++;
                        r.status = olu_pkg::ST_DONE;
                    end
                end
            end
            olu_pkg::MODE_DEL_VALUE, olu_pkg::MODE_DEL_POS: begin
                at = (op.mode == olu_pkg::MODE_DEL_VALUE) ? hit :
                     (p >= 1 && p <= model_len) ? p - 1 : -1;
                if (at >= 0) begin
                    // close the gap
                    for (k = at; k < model_len - 1; k++) model_cells[k] = model_cells[k + 1];
                    model_len--;
                    r.status = olu_pkg::ST_DONE;
                end
            end
            olu_pkg::MODE_SEARCH: begin
                if (hit >= 0) begin
                    r.match_pos = 7'(hit + 1);
                    r.status = olu_pkg::ST_DONE;
                end
            end
            olu_pkg::MODE_READ: begin
                if (p >= 1 && p <= model_len) begin
                    r.read_value = model_cells[p - 1];
                    r.status = olu_pkg::ST_DONE;
                end
            end
            olu_pkg::MODE_MODIFY: begin
                if (hit >= 0) begin
                    model_cells[hit] = op.new_value;
                    r.status = olu_pkg::ST_DONE;
                end
            end
            default: ;
        endcase
        r.entry_count = 7'(model_len);
        return r;
    endfunction

    function automatic t_dir_row op_row(logic [2:0] m, logic [31:0] v, logic [7:0] p,
                                        logic [31:0] nv);
        t_dir_row row;
        row = '0;
        row.op = '{mode: m, value: v, position: p, new_value: nv};
        return row;
    endfunction

    function automatic t_dir_row chk_row(logic [2:0] m, logic [31:0] v, logic [7:0] p,
                                         logic [1:0] st, logic [31:0] rv, logic [6:0] rp,
                                         logic [6:0] cnt);
        t_dir_row row;
        row = op_row(m, v, p, 32'd0);
        row.typed = 1'b1;
        row.res = '{status: st, read_value: rv, match_pos: rp, entry_count: cnt};
        return row;
    endfunction

    // favor values already in the list so that hits and duplicates are common
    function automatic logic [31:0] pick_value();
        logic [31:0] edge_vals [4];
        edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                if (model_len > 0) return model_cells[$urandom_range(0, model_len - 1)];
                return $urandom;
            end
            5:       return edge_vals[$urandom_range(0, 3)];
            6, 7:    return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_position(logic [2:0] mode);
        int span;
        int unsigned roll;
        span = (mode == olu_pkg::MODE_INSERT) ? model_len + 1 : model_len;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 8'($urandom_range(0, 255));
        if (roll == 1) return 8'(span + 1);
        if (mode == olu_pkg::MODE_INSERT && roll < 8) return olu_pkg::POS_TAIL;
        if (span == 0) return 8'd1;
        return 8'($urandom_range(1, span));
    endfunction

    function automatic t_op_item draw_op(t_fill_trend trend);
        t_op_item op;
        int unsigned ins_w;
        int unsigned del_w;
        int unsigned pick;
        case (trend)
            TREND_GROW:  begin ins_w = 75; del_w = 5;  end
            TREND_MIXED: begin ins_w = 30; del_w = 20; end
            default:     begin ins_w = 10; del_w = 50; end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 2)
            op.mode = $urandom_range(0, 1) ? MODE_RSVD_7 : MODE_RSVD_6;
        else if (pick < 2 + ins_w)
            op.mode = olu_pkg::MODE_INSERT;
        else if (pick < 2 + ins_w + del_w)
            op.mode = $urandom_range(0, 1) ? olu_pkg::MODE_DEL_POS : olu_pkg::MODE_DEL_VALUE;
        else begin
            case ($urandom_range(0, 2))
                0:       op.mode = olu_pkg::MODE_SEARCH;
                1:       op.mode = olu_pkg::MODE_READ;
                default: op.mode = olu_pkg::MODE_MODIFY;
            endcase
        end
        op.value     = pick_value();
        op.position  = pick_position(op.mode);
        op.new_value = pick_value();
        return op;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_op(input t_op_item op, input bit typed, input t_list_result res);
        int unsigned gap;
        gap = src_quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        offer_op    = op;
        offer_typed = typed;
        offer_res   = res;
        i_mode      = op.mode;
        i_value     = op.value;
        i_position  = op.position;
        i_new_value = op.new_value;
        i_in_valid  = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        ops_sent++;
        @(negedge i_clk);
        // drop valid so the same transfer is not offered again
        i_in_valid = 1'b0;
    endtask

    task automatic wait_all_results();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic compare_field(input string fname, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            err_count++;
        end
    endtask

    // result sink: random stall per result, plus one long hold on request
    initial begin : result_sink
        int unsigned n;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                n = sink_quiet ? 0 : $urandom_range(0, 15);
            end
            if (n != 0) begin
                i_out_stall = 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_list_result want;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            want = apply_list_op(offer_op);
            if (offer_typed) want = offer_res;
            pending_results.push_back(want);
            mode_tally[offer_op.mode]++;
            if (want.status == olu_pkg::ST_FULL) full_rejects++;
            if (want.status == olu_pkg::ST_MISS) miss_count++;
            if (model_len > max_len_seen) max_len_seen = model_len;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no operation pending: status %0d, count %0d",
                       o_status, o_entry_count);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", want.status, o_status);
                compare_field("result_value", $signed(want.read_value), o_result_value);
                compare_field("result_position", want.match_pos, o_result_position);
                compare_field("entry_count", want.entry_count, o_entry_count);
            end
        end
    end

    // end the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_fill_trend trend;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_mode      = olu_pkg::MODE_INSERT;
        i_value     = '0;
        i_position  = '0;
        i_new_value = '0;
        offer_op    = '0;
        offer_typed = 1'b0;
        offer_res   = '0;

        // empty list: every lookup and bad insert misses
        dir_table.push_back(chk_row(olu_pkg::MODE_READ, 32'd0, 8'd1,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd0));
        dir_table.push_back(chk_row(olu_pkg::MODE_SEARCH, 32'd0, 8'd0,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd0));
        dir_table.push_back(chk_row(olu_pkg::MODE_DEL_VALUE, 32'd5, 8'd0,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd0));
        dir_table.push_back(chk_row(olu_pkg::MODE_DEL_POS, 32'd0, 8'd1,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd0));
        dir_table.push_back(chk_row(olu_pkg::MODE_MODIFY, 32'd0, 8'd0,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd0));
        dir_table.push_back(chk_row(olu_pkg::MODE_INSERT, 32'd1, 8'd2,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd0));
        dir_table.push_back(chk_row(olu_pkg::MODE_INSERT, 32'd1, 8'd0,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd0));
        dir_table.push_back(chk_row(olu_pkg::MODE_INSERT, 32'd1, 8'hFE,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd0));
        // tail insert into the empty list, then a head insert in front of it
        dir_table.push_back(chk_row(olu_pkg::MODE_INSERT, 32'h7FFF_FFFF, olu_pkg::POS_TAIL,
                                    olu_pkg::ST_DONE, 32'd0, 7'd0, 7'd1));
        dir_table.push_back(chk_row(olu_pkg::MODE_INSERT, 32'h8000_0000, 8'd1,
                                    olu_pkg::ST_DONE, 32'd0, 7'd0, 7'd2));
        dir_table.push_back(op_row(olu_pkg::MODE_INSERT, 32'hFFFF_FFFF, 8'd3, 32'd0));
        dir_table.push_back(chk_row(olu_pkg::MODE_INSERT, 32'd9, 8'h7F,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd3));
        dir_table.push_back(chk_row(olu_pkg::MODE_INSERT, 32'd9, 8'h80,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd3));
        dir_table.push_back(op_row(olu_pkg::MODE_READ, 32'd0, 8'd1, 32'd0));
        dir_table.push_back(op_row(olu_pkg::MODE_READ, 32'd0, 8'd3, 32'd0));
        dir_table.push_back(chk_row(olu_pkg::MODE_READ, 32'd0, 8'd4,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd3));
        dir_table.push_back(chk_row(olu_pkg::MODE_READ, 32'd0, olu_pkg::POS_TAIL,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd3));
        dir_table.push_back(op_row(olu_pkg::MODE_SEARCH, 32'h7FFF_FFFF, 8'd0, 32'd0));
        dir_table.push_back(op_row(olu_pkg::MODE_MODIFY, 32'h7FFF_FFFF, 8'd0,
                                   32'h5A5A_5A5A));
        dir_table.push_back(chk_row(olu_pkg::MODE_MODIFY, 32'd12345, 8'd0,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd3));
        // duplicate value: search and delete must take the first match
        dir_table.push_back(op_row(olu_pkg::MODE_INSERT, 32'hFFFF_FFFF, 8'd2, 32'd0));
        dir_table.push_back(op_row(olu_pkg::MODE_SEARCH, 32'hFFFF_FFFF, 8'd0, 32'd0));
        dir_table.push_back(op_row(olu_pkg::MODE_DEL_VALUE, 32'hFFFF_FFFF, 8'd0, 32'd0));
        dir_table.push_back(op_row(olu_pkg::MODE_DEL_POS, 32'd0, 8'd3, 32'd0));
        dir_table.push_back(chk_row(MODE_RSVD_6, 32'd0, 8'd1,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd2));
        dir_table.push_back(chk_row(MODE_RSVD_7, 32'd0, 8'd1,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd2));
        dir_table.push_back(chk_row(olu_pkg::MODE_DEL_POS, 32'd0, 8'd0,
                                    olu_pkg::ST_MISS, 32'd0, 7'd0, 7'd2));

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_table[r]) send_op(dir_table[r].op, dir_table[r].typed, dir_table[r].res);
        wait_all_results();

        // grow, churn and drain the list in blocks
        for (int b = 0; b < RAND_BLOCKS; b++) begin
            case (b % 3)
                0:       trend = TREND_GROW;
                1:       trend = TREND_MIXED;
                default: trend = TREND_SHRINK;
            endcase
            src_quiet  = (b == 3 || b == 5);
            sink_quiet = (b == 3);
            // hold the output back while inputs keep coming
            if (b == 5) hold_req = 1'b1;
            // let the pipeline run dry before going on
            if (b == 8) wait_all_results();
            for (int n = 0; n < ITEMS_PER_BLOCK; n++) send_op(draw_op(trend), 1'b0, '0);
        end
        i_in_valid = 1'b0;

        wait_all_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Ran %0d operations, %0d results checked, peak list length %0d of %0d.",
                 ops_sent, results_seen, max_len_seen, LIST_DEPTH);
        $display("Per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d; misses %0d, full rejects %0d.",
                 mode_tally[0], mode_tally[1], mode_tally[2], mode_tally[3],
                 mode_tally[4], mode_tally[5], mode_tally[6], mode_tally[7],
                 miss_count, full_rejects);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
